@@ hdl/tbl_pkg.sv @@
// Shared types, codes and constants of the template brace lexer.
package tbl_pkg;

  // Byte codes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Result token kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_IDENT = 2'd1;
  localparam logic [1:0] KIND_OPEN  = 2'd2;
  localparam logic [1:0] KIND_CLOSE = 2'd3;

  // Open token codes
  localparam logic [1:0] TK_NONE  = 2'd0;
  localparam logic [1:0] TK_TEXT  = 2'd1;
  localparam logic [1:0] TK_IDENT = 2'd2;

  // Held brace codes
  localparam logic [1:0] PB_NONE  = 2'd0;
  localparam logic [1:0] PB_OPEN  = 2'd1;
  localparam logic [1:0] PB_CLOSE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_IDENT_MAX = 2'd0;
  localparam logic [1:0] REG_TEXT_MAX  = 2'd1;

  localparam logic [6:0] IDENT_MAX_RST = 7'd99;
  localparam logic [9:0] TEXT_MAX_RST  = 10'd1023;

  // Result queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic       in_var;
    logic [1:0] pend;
    logic [1:0] tk;
    logic [9:0] tlen;
    logic       skip;
  } lex_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       first;
  } tok_t;

  // Results caused by one input byte (cnt is 0, 1 or 2)
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       r0;
    tok_t       r1;
  } q_entry_t;

  typedef struct packed {
    lex_state_t st;
    q_entry_t   ent;
  } lex_ctx_t;

  typedef struct packed {
    logic     push;
    q_entry_t ent;
  } q_wr_t;

  typedef struct packed {
    logic     valid;
    logic     full;
    q_entry_t ent;
  } q_rd_t;

endpackage

@@ hdl/tbl_front.sv @@
// Front part: accepts bytes, runs the lexer state and forms result entries.
module tbl_front import tbl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  input  logic [7:0] in_char,
  input  logic       in_end,
  input  logic       q_full,
  output logic       in_ready,
  output q_wr_t      q_wr
);

  logic [6:0] ident_max_r;
  logic [9:0] text_max_r;
  lex_state_t state_r;
  lex_ctx_t   ctx_nxt;
  logic       take;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_brace(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE);
  endfunction

  function automatic lex_ctx_t f_emit(input lex_ctx_t x, input logic [1:0] kind,
                                      input logic [7:0] c, input logic first);
    tok_t t;
    t.kind  = kind;
    t.ch    = (kind == KIND_TEXT || kind == KIND_IDENT) ? c : 8'd0;
    t.first = first;
    if (x.ent.cnt == 2'd0) begin
      x.ent.r0  = t;
      x.ent.cnt = 2'd1;
    end else if (x.ent.cnt == 2'd1) begin
      x.ent.r1  = t;
      x.ent.cnt = 2'd2;
    end
    return x;
  endfunction

  function automatic logic at_cap(input lex_state_t s, input logic [6:0] im,
                                  input logic [9:0] tm);
    logic [9:0] c;
    c = (s.tk == TK_IDENT) ? {3'd0, im} : tm;
    if (c == 10'd0) c = 10'd1;
    return s.tlen >= c;
  endfunction

  function automatic lex_ctx_t f_close(input lex_ctx_t x);
    x.st.skip = (x.st.tk == TK_IDENT);
    x.st.tk   = TK_NONE;
    x.st.tlen = 10'd0;
    return x;
  endfunction

  function automatic lex_ctx_t f_start(input lex_ctx_t x, input logic [7:0] c,
                                       input logic [6:0] im, input logic [9:0] tm);
    x.st.tk   = x.st.in_var ? TK_IDENT : TK_TEXT;
    x.st.tlen = 10'd1;
    x.st.skip = 1'b0;
    x = f_emit(x, (x.st.tk == TK_IDENT) ? KIND_IDENT : KIND_TEXT, c, 1'b1);
    if (at_cap(x.st, im, tm)) x = f_close(x);
    return x;
  endfunction

  function automatic lex_ctx_t f_boundary(input lex_ctx_t x, input logic [7:0] c,
                                          input logic [6:0] im, input logic [9:0] tm);
    if (x.st.skip && is_ws(c)) begin
      return x;
    end
    if (is_brace(c)) begin
      x.st.pend = (c == CH_LBRACE) ? PB_OPEN : PB_CLOSE;
      x.st.skip = 1'b0;
      return x;
    end
    return f_start(x, c, im, tm);
  endfunction

  function automatic lex_ctx_t f_feed(input lex_ctx_t x, input logic [7:0] c,
                                      input logic [6:0] im, input logic [9:0] tm);
    logic ends;
    if (x.st.tk == TK_TEXT || x.st.tk == TK_IDENT) begin
      ends = (x.st.tk == TK_TEXT) ? is_brace(c) : is_ws(c);
      if (ends) begin
        x = f_close(x);
        return f_boundary(x, c, im, tm);
      end
      x.st.tlen = x.st.tlen + 10'd1;
      x = f_emit(x, (x.st.tk == TK_IDENT) ? KIND_IDENT : KIND_TEXT, c, 1'b0);
      if (at_cap(x.st, im, tm)) x = f_close(x);
      return x;
    end
    return f_boundary(x, c, im, tm);
  endfunction

  // Advance the lexer by one byte
  always_comb begin
    logic [7:0] held;
    lex_ctx_t   x;
    held  = CH_LBRACE;
    x.st  = state_r;
    x.ent = '0;
    if (x.st.pend == PB_OPEN || x.st.pend == PB_CLOSE) begin
      held      = (x.st.pend == PB_OPEN) ? CH_LBRACE : CH_RBRACE;
      x.st.pend = PB_NONE;
      if (in_char == held) begin
        if (held == CH_LBRACE) begin
          x.st.in_var = 1'b1;
          x.st.skip   = 1'b1;
          x = f_emit(x, KIND_OPEN, 8'd0, 1'b1);
        end else begin
          x.st.in_var = 1'b0;
          x.st.skip   = 1'b0;
          x = f_emit(x, KIND_CLOSE, 8'd0, 1'b1);
        end
      end else begin
        x = f_start(x, held, ident_max_r, text_max_r);
        x = f_feed(x, in_char, ident_max_r, text_max_r);
      end
    end else begin
      x.st.pend = PB_NONE;
      x = f_feed(x, in_char, ident_max_r, text_max_r);
    end
    // Flush a held brace and return to start at stream end
    if (in_end) begin
      if (x.st.pend == PB_OPEN || x.st.pend == PB_CLOSE) begin
        held      = (x.st.pend == PB_OPEN) ? CH_LBRACE : CH_RBRACE;
        x.st.pend = PB_NONE;
        x = f_start(x, held, ident_max_r, text_max_r);
      end
      x.st = '{in_var: 1'b0, pend: PB_NONE, tk: TK_NONE, tlen: 10'd0, skip: 1'b1};
    end
    ctx_nxt = x;
  end

  assign in_ready    = !q_full;
  assign take        = in_valid && in_ready;
  assign q_wr.push   = take && (ctx_nxt.ent.cnt != 2'd0);
  assign q_wr.ent    = ctx_nxt.ent;

  // Hold lexer state; advance on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{in_var: 1'b0, pend: PB_NONE, tk: TK_NONE, tlen: 10'd0, skip: 1'b1};
    end else if (take) begin
      state_r <= ctx_nxt.st;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_max_r <= IDENT_MAX_RST;
      text_max_r  <= TEXT_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IDENT_MAX: ident_max_r <= cfg_data[6:0];
        REG_TEXT_MAX:  text_max_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  a_push_has_results: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> (q_wr.ent.cnt == 2'd1 || q_wr.ent.cnt == 2'd2))
    else $error("entry pushed with no results");

endmodule

@@ hdl/tbl_queue.sv @@
// Short queue of result entries between the front and back parts.
module tbl_queue import tbl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  input  logic  pop,
  output q_rd_t q_rd
);

  q_entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wptr_r;
  logic [Q_AW-1:0]   rptr_r;
  logic [Q_AW:0]     count_r;
  logic [Q_AW:0]     count_nxt;

  assign q_rd.valid = (count_r != '0);
  assign q_rd.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign q_rd.ent   = mem_r[rptr_r];

  // Track fill level
  always_comb begin
    count_nxt = count_r;
    if (q_wr.push && !pop) count_nxt = count_r + 1'b1;
    else if (!q_wr.push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (q_wr.push) wptr_r <= wptr_r + 1'b1;
      if (pop)       rptr_r <= rptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (q_wr.push) mem_r[wptr_r] <= q_wr.ent;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && !pop && q_rd.full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_rd.valid)
    else $error("queue pop while empty");

endmodule

@@ hdl/tbl_back.sv @@
// Back part: splits queued entries into single results behind an output register.
module tbl_back import tbl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_rd_t q_rd,
  output logic  pop,
  input  logic  out_ready,
  output logic  out_valid,
  output tok_t  out_tok,
  output logic  out_last
);

  logic sel_r;
  logic sel_nxt;
  logic valid_r;
  tok_t tok_r;
  logic last_r;
  logic load;
  logic last_nxt;

  // Load the output register when it is empty or being drained
  assign load     = q_rd.valid && (!valid_r || out_ready);
  assign last_nxt = sel_r || (q_rd.ent.cnt == 2'd1);
  assign pop      = load && last_nxt;

  always_comb begin
    sel_nxt = sel_r;
    if (load) sel_nxt = !last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (load) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= sel_r ? q_rd.ent.r1 : q_rd.ent.r0;
      last_r <= last_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !last_nxt) |=> sel_r)
    else $error("second result of an entry not selected");

endmodule

@@ hdl/template_brace_lexer.sv @@
// Top level of the template brace lexer.
// Takes one template byte per cycle unless the queue is full and emits one
// result per token byte ({{ and }} give one open or close result each) via
// the queue and the output register. The output port moves one result per
// cycle while out_tready is high, so a byte that gives two results (a held
// lone brace flushed together with the next byte) needs a second output
// transfer; the four-entry queue between the lexer front and the output
// stage absorbs this. Bytes with no result (skipped whitespace, a brace held
// for lookahead) are still consumed. Configuration writes are taken at once.
module template_brace_lexer import tbl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic       in_tlast,   // stream_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_out
  output logic [2:0] out_tuser,  // [1:0] tok_kind, [2] tok_first
  output logic       out_tlast   // run_last
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  pop;
  tok_t  tok;

  assign cfg_ready = 1'b1;

  tbl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_char   (in_tdata),
    .in_end    (in_tlast),
    .q_full    (q_rd.full),
    .in_ready  (in_tready),
    .q_wr      (q_wr)
  );

  tbl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (pop),
    .q_rd  (q_rd)
  );

  tbl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_tok   (tok),
    .out_last  (out_tlast)
  );

  assign out_tdata = tok.ch;
  assign out_tuser = {tok.first, tok.kind};

endmodule
